/* design/fdcc_pkg.sv */
package fdcc_pkg;

  // Directory entry field values used by the checks.
  localparam logic [7:0] LONG_ATTR      = 8'h0F;
  localparam logic [7:0] FIRST_LONG_BIT = 8'h40;
  localparam logic [7:0] ORD_MASK       = 8'h3F;
  localparam logic [7:0] SPACE_BYTE     = 8'h20;
  localparam logic [7:0] TENTHS_LIMIT   = 8'd200;
  localparam logic [7:0] ATTR_RDONLY    = 8'h01;
  localparam logic [7:0] ATTR_HID       = 8'h02;
  localparam logic [7:0] ATTR_SYS       = 8'h04;
  localparam logic [7:0] ATTR_VOLUME    = 8'h08;
  localparam logic [7:0] ATTR_SUBDIR    = 8'h10;
  localparam logic [7:0] ATTR_ARC       = 8'h20;

  // Width of a long-name ordinal.
  localparam int unsigned ORD_W = 6;

  // Walk phase inside one cluster.
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_LONG   = 2'd1,
    PH_FREE   = 2'd2,
    PH_REJECT = 2'd3
  } phase_t;

  // Fields of one directory entry word.
  typedef struct packed {
    logic [7:0]  name_first;
    logic [7:0]  attr_bits;
    logic [7:0]  reserved_byte;
    logic [7:0]  create_tenths;
    logic [15:0] cluster_low;
    logic        last_entry;
  } entry_t;

  // Per-cluster walk state.
  typedef struct packed {
    phase_t             phase;
    logic [ORD_W-1:0]   remaining_long;
    logic               at_cluster_start;
  } walk_t;

  localparam walk_t WALK_RESET = '{
    phase:            PH_NORMAL,
    remaining_long:   '0,
    at_cluster_start: 1'b1
  };

  // True when the attribute is exactly one standard attribute bit.
  function automatic logic single_standard_attr(input logic [7:0] a);
    return (a == ATTR_RDONLY) || (a == ATTR_HID) || (a == ATTR_SYS) ||
           (a == ATTR_VOLUME) || (a == ATTR_SUBDIR) || (a == ATTR_ARC);
  endfunction

endpackage

/* design/fdcc_entry_if.sv */
interface fdcc_entry_if;
  logic        valid;
  logic        ready;
  logic [7:0]  name_first;
  logic [7:0]  attr_bits;
  logic [7:0]  reserved_byte;
  logic [7:0]  create_tenths;
  logic [15:0] cluster_low;
  logic        last_entry;

  modport source (output valid, name_first, attr_bits, reserved_byte, create_tenths,
                  cluster_low, last_entry, input ready);
  modport sink   (input valid, name_first, attr_bits, reserved_byte, create_tenths,
                  cluster_low, last_entry, output ready);
endinterface

/* design/fdcc_result_if.sv */
interface fdcc_result_if;
  logic valid;
  logic ready;
  logic is_directory;

  modport source (output valid, is_directory, input ready);
  modport sink   (input valid, is_directory, output ready);
endinterface

/* design/fdcc_entry_check.sv */
module fdcc_entry_check (
  input  fdcc_pkg::walk_t  cur,
  input  fdcc_pkg::entry_t ent,
  output fdcc_pkg::walk_t  nxt
);
  import fdcc_pkg::*;

  logic [ORD_W-1:0] ord;
  logic [ORD_W-1:0] rem_dec;
  logic             short_ok;

  assign ord      = ent.name_first[ORD_W-1:0];
  assign rem_dec  = cur.remaining_long - ORD_W'(1);
  assign short_ok = (ent.reserved_byte == 8'd0) && (ent.create_tenths < TENTHS_LIMIT) &&
                    single_standard_attr(ent.attr_bits);

  // Next phase and expected ordinal for one entry.
  always_comb begin
    nxt = cur;
    if (cur.phase == PH_REJECT) begin
      nxt.phase = PH_REJECT;
    end else if (cur.at_cluster_start && (ent.name_first == 8'd0)) begin
      nxt.phase = PH_REJECT;
    end else begin
      case (cur.phase)
        PH_FREE: begin
          if (ent.name_first != 8'd0) nxt.phase = PH_REJECT;
        end
        PH_LONG: begin
          if ((ent.attr_bits != LONG_ATTR) || (ent.cluster_low != 16'd0) ||
              (ent.name_first != {{(8-ORD_W){1'b0}}, cur.remaining_long})) begin
            nxt.phase = PH_REJECT;
          end else begin
            nxt.remaining_long = rem_dec;
            nxt.phase          = (rem_dec == '0) ? PH_NORMAL : PH_LONG;
          end
        end
        PH_NORMAL: begin
          if (ent.name_first == SPACE_BYTE) begin
            nxt.phase = PH_REJECT;
          end else if (ent.name_first == 8'd0) begin
            nxt.phase = PH_FREE;
          end else if (ent.attr_bits == LONG_ATTR) begin
            // First stored entry of a long-name run carries the highest ordinal.
            if (((ent.name_first & FIRST_LONG_BIT) == 8'd0) || (ord == '0) ||
                (ent.cluster_low != 16'd0)) begin
              nxt.phase = PH_REJECT;
            end else if (ord == ORD_W'(1)) begin
              nxt.phase = PH_NORMAL;
            end else begin
              nxt.remaining_long = ord - ORD_W'(1);
              nxt.phase          = PH_LONG;
            end
          end else if (!short_ok) begin
            nxt.phase = PH_REJECT;
          end
        end
        default: nxt.phase = PH_REJECT;
      endcase
    end
  end

endmodule

/* design/fat_directory_cluster_classifier.sv */
// Classifies one FAT cluster as a directory or not from its 32-byte entries,
// one entry word per cycle with last_entry set on the cluster's final entry.
// Only that final entry yields a result word, is_directory, which is 1 when
// every entry of the cluster passed the name, short-entry and long-name-run
// checks; a long-name run still open at the end of the cluster is accepted.
// Throughput is one entry per cycle while no held result stalls input: the
// walk state is a single register updated from the registered entry. The
// result is registered behind the entry register, and a held result only
// stalls input once the next cluster's final entry reaches the entry register.
module fat_directory_cluster_classifier (
  input logic           clk,
  input logic           rst,
  fdcc_entry_if.sink    entry,
  fdcc_result_if.source result
);
  import fdcc_pkg::*;

  logic   ent_valid;
  entry_t ent;
  walk_t  walk;
  walk_t  walk_step;
  logic   out_free;
  logic   ent_drain;
  logic   out_valid;
  logic   is_dir;

  // An entry moves on unless it must emit a result into an occupied slot.
  assign out_free    = !out_valid || result.ready;
  assign ent_drain   = ent_valid && (!ent.last_entry || out_free);
  assign entry.ready = !ent_valid || ent_drain;

  // Entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (entry.ready) begin
      ent_valid <= entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry.ready && entry.valid) begin
      ent <= '{
        name_first:    entry.name_first,
        attr_bits:     entry.attr_bits,
        reserved_byte: entry.reserved_byte,
        create_tenths: entry.create_tenths,
        cluster_low:   entry.cluster_low,
        last_entry:    entry.last_entry
      };
    end
  end

  fdcc_entry_check u_check (
    .cur (walk),
    .ent (ent),
    .nxt (walk_step)
  );

  // Walk state; the final entry of a cluster returns it to the start.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= WALK_RESET;
    end else if (ent_drain) begin
      if (ent.last_entry) begin
        walk <= WALK_RESET;
      end else begin
        walk <= '{
          phase:            walk_step.phase,
          remaining_long:   walk_step.remaining_long,
          at_cluster_start: 1'b0
        };
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ent_drain && ent.last_entry) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_drain && ent.last_entry) begin
      is_dir <= (walk_step.phase != PH_REJECT);
    end
  end

  assign result.valid        = out_valid;
  assign result.is_directory = is_dir;

  // A long-name run always has an ordinal still to come.
  a_long_has_ordinal: assert property (@(posedge clk) disable iff (rst)
    (walk.phase == PH_LONG) |-> (walk.remaining_long != '0))
    else $error("long-name run with zero expected ordinal");

  // The final entry of a cluster leaves the walk at a fresh cluster start.
  a_cluster_restart: assert property (@(posedge clk) disable iff (rst)
    (ent_drain && ent.last_entry) |=> (walk.at_cluster_start && (walk.phase == PH_NORMAL)))
    else $error("walk not restarted after final entry");

  // Any other entry clears the cluster start flag.
  a_start_cleared: assert property (@(posedge clk) disable iff (rst)
    (ent_drain && !ent.last_entry) |=> !walk.at_cluster_start)
    else $error("cluster start flag kept after an entry");

  // Input stalls only behind a final entry waiting on a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !entry.ready |-> (ent_valid && ent.last_entry && out_valid && !result.ready))
    else $error("input stalled without a held result");

  // A final entry that drains always produces a result word next cycle.
  a_result_made: assert property (@(posedge clk) disable iff (rst)
    (ent_drain && ent.last_entry) |=> out_valid)
    else $error("final entry produced no result");

endmodule
